// ===== src/bre_pkg.sv =====
package bre_pkg;

    localparam int unsigned PROB_W     = 12;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned MAX_BYTES  = 8;
    localparam int unsigned CNT_W      = 3;

    localparam int unsigned BRE_QUEUE_DEPTH = 2;

    localparam logic [WORD_W-1:0] LOW_RESET   = 32'h0000_0000;
    localparam logic [WORD_W-1:0] RANGE_RESET = 32'hFFFF_FFFF;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // Index of the final byte of a flush.
    localparam logic [CNT_W-1:0] FLUSH_LAST_IDX = 3'd3;
    // Index of the final byte a single item may emit.
    localparam logic [CNT_W-1:0] BURST_LAST_IDX = 3'(MAX_BYTES - 1);

    typedef struct packed {
        logic              flush;
        logic              bit_val;
        logic [PROB_W-1:0] prob;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_UPDATE,
        BK_NORM,
        BK_FLUSH
    } t_back_state;

endpackage

// ===== src/bre_in_if.sv =====
interface bre_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic                       bit_req;
    logic [bre_pkg::PROB_W-1:0] prob;

    modport source (output valid, output cmd, output bit_req, output prob, input ready);
    modport sink   (input valid, input cmd, input bit_req, input prob, output ready);
endinterface

// ===== src/bre_out_if.sv =====
interface bre_out_if;
    logic                       valid;
    logic                       ready;
    logic [bre_pkg::BYTE_W-1:0] out_byte;
    logic                       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== src/bre_queue.sv =====
module bre_queue #(
    parameter int unsigned DEPTH = bre_pkg::BRE_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bre_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output bre_pkg::t_job o_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bre_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== src/bre_front.sv =====
module bre_front (
    bre_in_if.sink        i_item,
    input  logic          i_full,
    output logic          o_push,
    output bre_pkg::t_job o_job
);

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    always_comb begin
        o_job.flush   = (i_item.cmd == bre_pkg::CMD_FLUSH);
        o_job.bit_val = i_item.bit_req;
        // A zero probability would collapse the interval, so it codes as the smallest one.
        o_job.prob    = (i_item.prob == '0) ? bre_pkg::PROB_W'(1) : i_item.prob;
    end

endmodule

// ===== src/bre_back.sv =====
module bre_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  bre_pkg::t_job i_job,
    output logic          o_pop,
    bre_out_if.source     o_res
);

    localparam int unsigned W = bre_pkg::WORD_W;

    bre_pkg::t_back_state r_state, n_state;
    logic [W-1:0]                 r_low,   n_low;
    logic [W-1:0]                 r_range, n_range;
    logic [W-1:0]                 r_r1,    n_r1;
    logic                         r_bit,   n_bit;
    logic                         r_phase, n_phase;
    logic [bre_pkg::CNT_W-1:0]    r_cnt,   n_cnt;
    logic                         r_out_valid, n_out_valid;
    logic [bre_pkg::BYTE_W-1:0]   r_out_byte,  n_out_byte;
    logic                         r_out_last,  n_out_last;

    logic [W-1:0] w_prod;
    logic [W-1:0] w_r0;
    logic [W-1:0] w_sum;
    logic [W-1:0] w_diff;
    logic         w_out_free;
    logic         w_hit_top;
    logic         w_hit_bot;
    logic         w_more;

    assign w_prod = {{(W-20){1'b0}}, r_range[W-1:12]}
                  * {{(W-bre_pkg::PROB_W){1'b0}}, i_job.prob};
    assign w_r0   = r_range - r_r1;
    assign w_sum  = r_low + r_range;
    assign w_diff = r_low ^ w_sum;

    // Top byte of low is settled once low and low + range agree in it.
    assign w_hit_top  = !r_phase && (w_diff[31:24] == '0);
    assign w_hit_bot  = (r_range[31:16] == '0);
    assign w_out_free = !r_out_valid || o_res.ready;

    assign o_res.valid    = r_out_valid;
    assign o_res.out_byte = r_out_byte;
    assign o_res.last     = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_range     = r_range;
        n_r1        = r_r1;
        n_bit       = r_bit;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        w_more      = 1'b0;

        case (r_state)
            bre_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    n_cnt = '0;
                    if (i_job.flush) begin
                        n_state = bre_pkg::BK_FLUSH;
                    end else begin
                        n_r1    = w_prod;
                        n_bit   = i_job.bit_val;
                        n_state = bre_pkg::BK_UPDATE;
                    end
                end
            end
            bre_pkg::BK_UPDATE: begin
                if (r_bit) begin
                    n_low   = r_low + w_r0;
                    n_range = r_r1;
                end else begin
                    n_range = w_r0;
                end
                n_phase = 1'b0;
                n_state = bre_pkg::BK_NORM;
            end
            bre_pkg::BK_NORM: begin
                if (!w_hit_top && !w_hit_bot) begin
                    n_state = bre_pkg::BK_IDLE;
                end else if (w_out_free) begin
                    // Look one step ahead so the final byte carries its last flag.
                    n_low = {r_low[W-9:0], 8'h00};
                    if (w_hit_top) begin
                        n_range = {r_range[W-9:0], 8'h00};
                        w_more  = (w_diff[23:16] == '0) || (r_range[23:8] == '0);
                    end else begin
                        n_range = {~r_low[W-9:0], 8'h00};
                        n_phase = 1'b1;
                        w_more  = ((~r_low[23:8]) == '0);
                    end
                    w_more      = w_more && (r_cnt != bre_pkg::BURST_LAST_IDX);
                    n_out_valid = 1'b1;
                    n_out_byte  = r_low[31:24];
                    n_out_last  = !w_more;
                    n_cnt       = r_cnt + 1'b1;
                    if (!w_more) begin
                        n_state = bre_pkg::BK_IDLE;
                    end
                end
            end
            bre_pkg::BK_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_low[31:24];
                    n_out_last  = (r_cnt == bre_pkg::FLUSH_LAST_IDX);
                    n_low       = {r_low[W-9:0], 8'h00};
                    n_cnt       = r_cnt + 1'b1;
                    if (r_cnt == bre_pkg::FLUSH_LAST_IDX) begin
                        n_low   = bre_pkg::LOW_RESET;
                        n_range = bre_pkg::RANGE_RESET;
                        n_state = bre_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = bre_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bre_pkg::BK_IDLE;
            r_low       <= bre_pkg::LOW_RESET;
            r_range     <= bre_pkg::RANGE_RESET;
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_low       <= n_low;
            r_range     <= n_range;
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r1       <= n_r1;
        r_bit      <= n_bit;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

endmodule

// ===== src/binary_range_encoder.sv =====
// An encode word is taken from the queue together with the multiply, then goes through the interval
// update and a normalization loop that emits one byte per cycle while the output is not stalled.
// A flush emits the four bytes of low, one per cycle while the output is not stalled. The coder
// takes the next word only once it is done with the last. A small queue buffers input words.
// Reset (synchronous, active low) empties the queue, drops any pending byte and sets
// low to zero and range to all ones.
module binary_range_encoder #(
    parameter int unsigned QUEUE_DEPTH = bre_pkg::BRE_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bre_in_if.sink    i_item,
    bre_out_if.source o_res
);

    logic          w_full;
    logic          w_push;
    logic          w_pop;
    logic          w_q_valid;
    bre_pkg::t_job w_in_job;
    bre_pkg::t_job w_head_job;

    bre_front u_front (
        .i_item (i_item),
        .i_full (w_full),
        .o_push (w_push),
        .o_job  (w_in_job)
    );

    bre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_head_job)
    );

    bre_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_job     (w_head_job),
        .o_pop     (w_pop),
        .o_res     (o_res)
    );

endmodule

// ===== src/bre_checker.sv =====
module bre_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [bre_pkg::BYTE_W-1:0] i_out_byte,
    input logic                       i_out_last
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic       r_seen;
    logic [3:0] r_run;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // Set once the first input word has been taken in since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (w_in_acc) begin
            r_seen <= 1'b1;
        end
    end

    // Words delivered since the last one that closed an item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (w_out_acc) begin
            r_run <= i_out_last ? '0 : r_run + 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("output word changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("ports not idle after reset");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> r_seen || w_in_acc)
        else $error("output word without an accepted input item");

    a_burst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && !i_out_last |-> r_run < 4'(bre_pkg::MAX_BYTES - 1))
        else $error("more than eight words for one item");

endmodule

bind binary_range_encoder bre_checker u_bre_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_byte  (o_res.out_byte),
    .i_out_last  (o_res.last)
);

// ===== bench/binary_range_encoder_test.sv =====
module binary_range_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RUN_LIMIT   = 400000;
    localparam int unsigned TAIL_CYCLES = 16;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned GAP_MAX     = 7;
    localparam int unsigned FLUSH_BYTES = 4;

    localparam logic [bre_pkg::WORD_W-1:0] TOP_LIMIT = 32'h0100_0000;
    localparam logic [bre_pkg::WORD_W-1:0] BOT_LIMIT = 32'h0001_0000;

    typedef struct packed {
        logic [bre_pkg::BYTE_W-1:0] out_byte;
        logic                       last;
    } t_coded_byte;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bre_in_if  item_if ();
    bre_out_if res_if ();

    binary_range_encoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if)
    );

    always #1 i_clk = ~i_clk;

    // Interval state of the predicted coder and the bytes it has yet to see.
    logic [bre_pkg::WORD_W-1:0] coder_low;
    logic [bre_pkg::WORD_W-1:0] coder_range;
    t_coded_byte                stream_bytes [$];

    bit          send_idle     = 1'b0;
    bit          recv_idle     = 1'b0;
    int unsigned cycle_count   = 0;
    int unsigned mismatches    = 0;
    int unsigned bytes_checked = 0;
    int unsigned words_sent    = 0;
    int unsigned flushes_sent  = 0;

    function automatic void reset_coder();
        coder_low   = bre_pkg::LOW_RESET;
        coder_range = bre_pkg::RANGE_RESET;
    endfunction

    // Advances the predicted coder by one accepted word and queues the bytes it emits.
    function automatic void code_word(logic cmd, logic bit_val,
                                      logic [bre_pkg::PROB_W-1:0] prob);
        logic [bre_pkg::BYTE_W-1:0] burst [bre_pkg::MAX_BYTES];
        int                         n;
        logic [bre_pkg::WORD_W-1:0] p;
        logic [bre_pkg::WORD_W-1:0] r1;
        logic [bre_pkg::WORD_W-1:0] r0;
        logic [bre_pkg::WORD_W-1:0] upper;
        t_coded_byte                entry;
        n = 0;
        if (cmd == bre_pkg::CMD_FLUSH) begin
            for (int i = 0; i < FLUSH_BYTES; i++) begin
                burst[i] = coder_low[bre_pkg::WORD_W-1-bre_pkg::BYTE_W*i -: bre_pkg::BYTE_W];
            end
            n = FLUSH_BYTES;
            reset_coder();
        end else begin
            // A probability of zero is coded as one so the interval never collapses.
            p  = (prob == '0) ? bre_pkg::WORD_W'(1) : bre_pkg::WORD_W'(prob);
            r1 = (coder_range >> bre_pkg::PROB_W) * p;
            r0 = coder_range - r1;
            if (bit_val == 1'b0) begin
                coder_range = r0;
            end else begin
                coder_low   = coder_low + r0;
                coder_range = r1;
            end
            upper = coder_low + coder_range;
            while (n < bre_pkg::MAX_BYTES && (coder_low ^ upper) < TOP_LIMIT) begin
                burst[n]    = coder_low[bre_pkg::WORD_W-1 -: bre_pkg::BYTE_W];
                n++;
                coder_low   = coder_low << bre_pkg::BYTE_W;
                coder_range = coder_range << bre_pkg::BYTE_W;
                upper       = coder_low + coder_range;
            end
            while (n < bre_pkg::MAX_BYTES && coder_range < BOT_LIMIT) begin
                burst[n]    = coder_low[bre_pkg::WORD_W-1 -: bre_pkg::BYTE_W];
                n++;
                coder_range = (~coder_low) << bre_pkg::BYTE_W;
                coder_low   = coder_low << bre_pkg::BYTE_W;
            end
        end
        for (int i = 0; i < n; i++) begin
            entry.out_byte = burst[i];
            entry.last     = (i == n - 1);
            stream_bytes   = {stream_bytes, entry};
        end
    endfunction

    // Valid stays high after acceptance so a back-to-back word needs no new rising edge on it.
    task automatic send_word(logic cmd, logic bit_val, logic [bre_pkg::PROB_W-1:0] prob);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, GAP_MAX) : 0;
        if (gap != 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid   <= 1'b1;
        item_if.cmd     <= cmd;
        item_if.bit_req <= bit_val;
        item_if.prob    <= prob;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        code_word(cmd, bit_val, prob);
        words_sent++;
        if (cmd == bre_pkg::CMD_FLUSH) begin
            flushes_sent++;
        end
    endtask

    task automatic send_decision(logic bit_val, logic [bre_pkg::PROB_W-1:0] prob);
        send_word(bre_pkg::CMD_ENCODE, bit_val, prob);
    endtask

    task automatic send_flush();
        send_word(bre_pkg::CMD_FLUSH, 1'($urandom_range(0, 1)),
                  bre_pkg::PROB_W'($urandom_range(0, 4095)));
    endtask

    task automatic drain_output();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (stream_bytes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Draws a decision the way a modeling stage would: mostly consistent with prob.
    task automatic send_modeled_decision();
        logic [bre_pkg::PROB_W-1:0] prob;
        logic                       bit_val;
        int unsigned                kind;
        kind = $urandom_range(0, 99);
        if (kind < 4) begin
            prob = '0;
        end else if (kind < 14) begin
            prob = bre_pkg::PROB_W'($urandom_range(1, 15));
        end else if (kind < 24) begin
            prob = bre_pkg::PROB_W'($urandom_range(4080, 4095));
        end else begin
            prob = bre_pkg::PROB_W'($urandom_range(0, 4095));
        end
        if (kind >= 90) begin
            bit_val = 1'($urandom_range(0, 1));
        end else begin
            bit_val = ($urandom_range(0, 4095) < prob);
        end
        send_decision(bit_val, prob);
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    task automatic test_flush_after_reset();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        send_flush();
    endtask

    task automatic test_field_extremes();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        // From reset a likely zero emits nothing.
        send_decision(1'b0, 12'd1);
        send_decision(1'b1, 12'd4095);
        send_decision(1'b0, 12'd4095);
        send_decision(1'b1, 12'd1);
        send_decision(1'b0, 12'd2048);
        send_decision(1'b1, 12'hAAA);
        send_flush();
    endtask

    task automatic test_zero_probability();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_decision(1'b0, 12'd0);
        send_decision(1'b1, 12'd0);
        send_decision(1'b1, 12'd0);
        send_decision(1'b1, 12'd0);
        send_flush();
    endtask

    task automatic test_long_bursts();
        send_idle = 1'b0;
        recv_idle = 1'b1;
        // Unlikely decisions shrink the interval hard and force long normalization bursts.
        repeat (4) send_decision(1'b1, 12'd1);
        repeat (4) send_decision(1'b0, 12'd4095);
        send_flush();
    endtask

    task automatic test_pause_until_drained();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        repeat (10) send_modeled_decision();
        drain_output();
        repeat (10) send_modeled_decision();
        send_flush();
    endtask

    task automatic test_random_stream();
        for (int blk = 0; blk < 10; blk++) begin
            // Some blocks run with no idling at all on one side or both.
            send_idle = ($urandom_range(0, 2) != 0);
            recv_idle = ($urandom_range(0, 2) != 0);
            repeat (38) begin
                if ($urandom_range(0, 31) == 0) begin
                    send_flush();
                end else begin
                    send_modeled_decision();
                end
            end
        end
        send_flush();
    endtask

    initial begin : result_checker
        int unsigned stall;
        t_coded_byte want;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = recv_idle ? $urandom_range(0, GAP_MAX) : 0;
            if (stall != 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n === 1'b1 && res_if.valid === 1'b1));
            bytes_checked++;
            if (stream_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected word: byte %02h last %b",
                                          res_if.out_byte, res_if.last));
            end else begin
                want = stream_bytes.pop_front();
                if (res_if.out_byte !== want.out_byte || res_if.last !== want.last) begin
                    report_mismatch($sformatf("expected byte %02h last %b, got byte %02h last %b",
                                              want.out_byte, want.last,
                                              res_if.out_byte, res_if.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Timed out after %0d cycles with %0d bytes outstanding.",
                     cycle_count, stream_bytes.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        item_if.valid   <= 1'b0;
        item_if.cmd     <= bre_pkg::CMD_ENCODE;
        item_if.bit_req <= 1'b0;
        item_if.prob    <= '0;
        reset_coder();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_flush_after_reset();
        test_field_extremes();
        test_zero_probability();
        test_long_bursts();
        test_pause_until_drained();
        test_random_stream();
        drain_output();

        $display("Coded %0d words including %0d flushes; checked %0d output bytes in %0d cycles.",
                 words_sent, flushes_sent, bytes_checked, cycle_count);
        $display("Covered probability extremes and zero, long bursts, and random stalls.");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches in total.", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bre_pkg.sv
src/bre_in_if.sv
src/bre_out_if.sv
src/bre_queue.sv
src/bre_front.sv
src/bre_back.sv
src/binary_range_encoder.sv
src/bre_checker.sv
bench/binary_range_encoder_test.sv
